>>> rtl/core/sgcf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgcf_pkg: shared types and constants of the sweep gain corner finder
// Beat formats, controller states, command/status bundles, frequency helpers.
// ----------------------------------------------------------------------------
package sgcf_pkg;

	localparam int SAMPLE_BITS = 12;
	localparam int MAX_POINTS  = 256;
	localparam int IDX_W       = $clog2(MAX_POINTS);
	localparam int CNT_W       = 9;
	localparam int RATIO_W     = 20;
	localparam int FREQ_W      = 24;
	localparam int STEP_W      = 16;
	localparam int FRAC_BITS   = 8;
	localparam int NUM_W       = SAMPLE_BITS + FRAC_BITS;
	localparam int DIV_STEPS   = NUM_W;
	localparam int DIV_CNT_W   = $clog2(DIV_STEPS);
	localparam int PROD_W      = IDX_W + STEP_W;
	localparam int SUM_W       = ((PROD_W > FREQ_W) ? PROD_W : FREQ_W) + 1;
	localparam int DIST_W      = RATIO_W + 1;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = FREQ_W;

	localparam logic [RATIO_W-1:0]     RATIO_SAT   = {RATIO_W{1'b1}};
	localparam logic [FREQ_W-1:0]      FREQ_SAT    = {FREQ_W{1'b1}};
	localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX  = {SAMPLE_BITS{1'b1}};

	localparam logic [FREQ_W-1:0] START_RESET = FREQ_W'(500);
	localparam logic [STEP_W-1:0] STEP_RESET  = STEP_W'(500);
	localparam logic [CNT_W-1:0]  COUNT_RESET = CNT_W'(200);

	localparam logic [CFG_IDX_W-1:0] CFG_START = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_STEP  = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] CFG_COUNT = CFG_IDX_W'(2);

	localparam logic REQ_SAMPLE = 1'b0;
	localparam logic REQ_CLOSE  = 1'b1;

	typedef struct packed {
		logic                   req_type;
		logic [SAMPLE_BITS-1:0] drive_sample;
		logic [SAMPLE_BITS-1:0] response_sample;
	} in_beat_t;

	typedef struct packed {
		logic [RATIO_W-1:0] point_ratio;
		logic [FREQ_W-1:0]  point_freq;
		logic               sweep_done;
		logic [FREQ_W-1:0]  corner_freq;
		logic [RATIO_W-1:0] corner_ratio;
		logic [RATIO_W-1:0] first_ratio;
		logic [RATIO_W-1:0] last_ratio;
	} out_beat_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_POINT,
		ST_WALK,
		ST_DRAIN,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic sample;
		logic close;
		logic div_step;
		logic point;
		logic walk_issue;
		logic fin_load;
	} cmd_t;

	typedef struct packed {
		logic last;
		logic walk_end;
		logic out_free;
	} status_t;

	// start + idx * step, clipped to the frequency field
	function automatic logic [FREQ_W-1:0] freq_of(input logic [FREQ_W-1:0] start,
			input logic [STEP_W-1:0] step, input logic [IDX_W-1:0] idx);
		logic [PROD_W-1:0] prod;
		logic [SUM_W-1:0]  sum;
		prod = PROD_W'(idx) * PROD_W'(step);
		sum  = SUM_W'(start) + SUM_W'(prod);
		if (sum > SUM_W'(FREQ_SAT)) begin
			return FREQ_SAT;
		end
		return sum[FREQ_W-1:0];
	endfunction

	// |2*r - max|
	function automatic logic [DIST_W-1:0] dist_to_half(input logic [RATIO_W-1:0] r,
			input logic [RATIO_W-1:0] m);
		logic [DIST_W-1:0] a;
		logic [DIST_W-1:0] b;
		a = {r, 1'b0};
		b = DIST_W'(m);
		return (a >= b) ? (a - b) : (b - a);
	endfunction

endpackage

>>> rtl/core/sweep_gain_corner_finder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sweep_gain_corner_finder: swept gain measurement with half-maximum search
// Ratio of response to drive spread per window, corner point at sweep end.
// ----------------------------------------------------------------------------
// Usage:
//   in channel (in_valid/in_ready/in_data): a sample beat (req_type 0) is
//   taken and only updates the window bounds; back-to-back sample beats
//   run at one per cycle while the block is idle.
//   A close beat (req_type 1) drops in_ready while the ratio is formed by a
//   serial divider, one quotient bit per cycle, then the point is stored
//   and the result beat is handed off to the output register; in_ready
//   returns once the hand-off is done. The last close of a sweep also walks
//   the point table through its single read port, one entry per cycle,
//   before the hand-off.
//   out channel (out_valid/out_ready/out_data): one beat per close. The
//   output register holds it while the receiver stalls; sample beats keep
//   flowing meanwhile, and the next close waits only at its hand-off.
//   cfg port (cfg_we/cfg_index/cfg_data): write start frequency, step and
//   point count while idle; unused indexes are ignored.
//   Reset returns registers to their defaults, reopens the window and
//   starts a new sweep at point 0. The table needs no clearing.
// ----------------------------------------------------------------------------
module sweep_gain_corner_finder
	import sgcf_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  in_beat_t              in_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output out_beat_t             out_data,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cmd_t    cmd;
	status_t status;

	// sequencer: owns in_ready and steps the datapath
	sgcf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.req_type (in_data.req_type),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	// datapath: bounds, divider, point table, corner search, output register
	sgcf_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_data   (in_data),
		.cmd       (cmd),
		.status    (status),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

>>> rtl/core/sgcf_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgcf_ctrl: sequencer of the sweep gain corner finder
// Steps a close through divide, table write, end-of-sweep walk and hand-off.
// ----------------------------------------------------------------------------
module sgcf_ctrl
	import sgcf_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	input  logic    req_type,
	output logic    in_ready,
	input  status_t status,
	output cmd_t    cmd
);

	state_t               state_q;
	state_t               state_d;
	logic [DIV_CNT_W-1:0] div_cnt_q;
	logic                 div_last;

	assign div_last = (div_cnt_q == DIV_CNT_W'(DIV_STEPS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			div_cnt_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_DIV) begin
				div_cnt_q <= div_cnt_q + 1'b1;
			end else begin
				div_cnt_q <= '0;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid && (req_type == REQ_CLOSE)) begin
					state_d = ST_DIV;
				end
			end
			ST_DIV: begin
				if (div_last) begin
					state_d = ST_POINT;
				end
			end
			ST_POINT: begin
				state_d = status.last ? ST_WALK : ST_FIN;
			end
			ST_WALK: begin
				if (status.walk_end) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_d = ST_FIN;
			end
			ST_FIN: begin
				if (status.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready   = 1'b1;
				cmd.sample = in_valid && (req_type == REQ_SAMPLE);
				cmd.close  = in_valid && (req_type == REQ_CLOSE);
			end
			ST_DIV:   cmd.div_step   = 1'b1;
			ST_POINT: cmd.point      = 1'b1;
			ST_WALK:  cmd.walk_issue = 1'b1;
			ST_DRAIN: ;
			ST_FIN:   cmd.fin_load   = status.out_free;
			default: ;
		endcase
	end

`ifndef SYNTHESIS
	a_point_after_full_divide: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_POINT) |-> ($past(state_q) == ST_DIV
			&& $past(div_cnt_q) == DIV_CNT_W'(DIV_STEPS - 1)))
		else $error("point stage entered without a full divide");
	a_drain_after_walk: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DRAIN) |-> ($past(state_q) == ST_WALK && $past(status.walk_end)))
		else $error("drain entered before the walk reached its end");
	a_close_starts_divide: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.close |=> (state_q == ST_DIV && div_cnt_q == '0))
		else $error("accepted close did not start the divider");
`endif

endmodule

>>> rtl/core/sgcf_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgcf_dp: datapath of the sweep gain corner finder
// Window bounds, serial divider, point table, corner search and result beat.
// ----------------------------------------------------------------------------
module sgcf_dp
	import sgcf_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  in_beat_t              in_data,
	input  cmd_t                  cmd,
	output status_t               status,
	output logic                  out_valid,
	input  logic                  out_ready,
	output out_beat_t             out_data
);

	// configuration
	logic [FREQ_W-1:0] start_q;
	logic [STEP_W-1:0] step_q;
	logic [CNT_W-1:0]  count_q;

	// window bounds
	logic [SAMPLE_BITS-1:0] resp_max_q, resp_min_q, drive_max_q, drive_min_q;

	// divider
	logic [NUM_W-1:0]       num_q;
	logic [NUM_W-1:0]       quo_q;
	logic [SAMPLE_BITS:0]   rem_q;
	logic [SAMPLE_BITS-1:0] divisor_q;
	logic                   sat_q;
	logic                   zero_q;
	logic [SAMPLE_BITS:0]   rem_sh;
	logic                   rem_ge;

	// sweep
	logic [IDX_W-1:0]   idx_q;
	logic [RATIO_W-1:0] sweep_max_q;
	logic [CNT_W-1:0]   n_eff;
	logic [RATIO_W-1:0] ratio_now;
	logic [RATIO_W-1:0] sweep_max_new;
	logic               last_now;

	// table and walk
	logic [RATIO_W-1:0] table_mem [MAX_POINTS];
	logic [IDX_W-1:0]   walk_end_q;
	logic [IDX_W-1:0]   rd_addr_q;
	logic [RATIO_W-1:0] rd_data_s1;
	logic [IDX_W-1:0]   rd_idx_s1;
	logic               rd_valid_s1;
	logic [DIST_W-1:0]  rd_dist;
	logic [IDX_W-1:0]   freq_idx;
	logic [FREQ_W-1:0]  freq_val;

	logic [RATIO_W-1:0] best_ratio_q;
	logic [DIST_W-1:0]  best_dist_q;
	logic [FREQ_W-1:0]  best_freq_q;
	logic [RATIO_W-1:0] first_q;
	logic [RATIO_W-1:0] pt_ratio_q;
	logic [FREQ_W-1:0]  pt_freq_q;
	logic               pt_last_q;

	out_beat_t out_q;
	logic      out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= START_RESET;
			step_q  <= STEP_RESET;
			count_q <= COUNT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_START: start_q <= cfg_data[FREQ_W-1:0];
				CFG_STEP:  step_q  <= cfg_data[STEP_W-1:0];
				CFG_COUNT: count_q <= cfg_data[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	// track bounds per sample, reopen the window on close
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			resp_max_q  <= '0;
			resp_min_q  <= SAMPLE_MAX;
			drive_max_q <= '0;
			drive_min_q <= SAMPLE_MAX;
		end else if (cmd.close) begin
			resp_max_q  <= '0;
			resp_min_q  <= SAMPLE_MAX;
			drive_max_q <= '0;
			drive_min_q <= SAMPLE_MAX;
		end else if (cmd.sample) begin
			if (in_data.response_sample > resp_max_q) resp_max_q <= in_data.response_sample;
			if (in_data.response_sample < resp_min_q) resp_min_q <= in_data.response_sample;
			if (in_data.drive_sample > drive_max_q) drive_max_q <= in_data.drive_sample;
			if (in_data.drive_sample < drive_min_q) drive_min_q <= in_data.drive_sample;
		end
	end

	// restoring divider, one quotient bit per cycle
	assign rem_sh = {rem_q[SAMPLE_BITS-1:0], num_q[NUM_W-1]};
	assign rem_ge = (rem_sh >= {1'b0, divisor_q});

	always_ff @(posedge clk) begin
		if (cmd.close) begin
			num_q     <= {resp_max_q - resp_min_q, {FRAC_BITS{1'b0}}};
			divisor_q <= drive_max_q - drive_min_q;
			sat_q     <= (drive_max_q <= drive_min_q);
			zero_q    <= (resp_max_q <= resp_min_q);
			rem_q     <= '0;
			quo_q     <= '0;
		end else if (cmd.div_step) begin
			num_q <= {num_q[NUM_W-2:0], 1'b0};
			rem_q <= rem_ge ? (rem_sh - {1'b0, divisor_q}) : rem_sh;
			quo_q <= {quo_q[NUM_W-2:0], rem_ge};
		end
	end

	always_comb begin
		if (sat_q) begin
			ratio_now = RATIO_SAT;
		end else if (zero_q) begin
			ratio_now = '0;
		end else if ((NUM_W + RATIO_W)'(quo_q) > (NUM_W + RATIO_W)'(RATIO_SAT)) begin
			ratio_now = RATIO_SAT;
		end else begin
			ratio_now = quo_q[RATIO_W-1:0];
		end
	end

	always_comb begin
		if (count_q == '0) begin
			n_eff = CNT_W'(1);
		end else if ((CNT_W + IDX_W + 1)'(count_q) > (CNT_W + IDX_W + 1)'(MAX_POINTS)) begin
			n_eff = CNT_W'(MAX_POINTS);
		end else begin
			n_eff = count_q;
		end
	end

	assign last_now      = ((CNT_W + IDX_W + 1)'(idx_q) + 1'b1) >= (CNT_W + IDX_W + 1)'(n_eff);
	assign sweep_max_new = (ratio_now > sweep_max_q) ? ratio_now : sweep_max_q;
	assign freq_idx      = cmd.point ? idx_q : rd_idx_s1;
	assign freq_val      = freq_of(start_q, step_q, freq_idx);
	assign rd_dist       = dist_to_half(rd_data_s1, sweep_max_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			sweep_max_q <= '0;
			rd_valid_s1 <= 1'b0;
		end else begin
			rd_valid_s1 <= cmd.walk_issue;
			if (cmd.point) begin
				sweep_max_q <= sweep_max_new;
				idx_q       <= last_now ? '0 : (idx_q + 1'b1);
			end else if (cmd.fin_load && pt_last_q) begin
				sweep_max_q <= '0;
			end
		end
	end

	// point table: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (cmd.point) begin
			table_mem[idx_q] <= ratio_now;
		end
		if (cmd.walk_issue) begin
			rd_data_s1 <= table_mem[rd_addr_q];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.point) begin
			pt_ratio_q <= ratio_now;
			pt_freq_q  <= freq_val;
			pt_last_q  <= last_now;
			walk_end_q <= idx_q;
			rd_addr_q  <= '0;
		end else if (cmd.walk_issue) begin
			rd_addr_q <= rd_addr_q + 1'b1;
			rd_idx_s1 <= rd_addr_q;
		end
		// point 0 seeds the search; later points replace it only when strictly closer
		if (rd_valid_s1) begin
			if (rd_idx_s1 == '0) begin
				best_ratio_q <= rd_data_s1;
				best_dist_q  <= rd_dist;
				best_freq_q  <= freq_val;
				first_q      <= rd_data_s1;
			end else if (rd_dist < best_dist_q) begin
				best_ratio_q <= rd_data_s1;
				best_dist_q  <= rd_dist;
				best_freq_q  <= freq_val;
			end
		end
	end

	assign status.last     = last_now;
	assign status.walk_end = (rd_addr_q == walk_end_q);
	assign status.out_free = !out_valid_q || out_ready;

	// output register: hold the beat until the receiver takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.fin_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.fin_load) begin
			out_q.point_ratio  <= pt_ratio_q;
			out_q.point_freq   <= pt_freq_q;
			out_q.sweep_done   <= pt_last_q;
			out_q.corner_freq  <= pt_last_q ? best_freq_q : '0;
			out_q.corner_ratio <= pt_last_q ? best_ratio_q : '0;
			out_q.first_ratio  <= pt_last_q ? first_q : '0;
			out_q.last_ratio   <= pt_last_q ? pt_ratio_q : '0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule
